// ===== rtl/rpn_stack_calculator_defines.svh =====
// Assertion macros used by the checker file of the stack calculator.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rsc_pkg.sv =====
// Shared types, widths and codes of the stack calculator.
package rsc_pkg;

   localparam int WORD_W              = 32;
   localparam int OP_W                = 3;
   localparam int LINE_W              = 16;
   localparam int STATUS_W            = 3;
   localparam int DEPTH_W             = 7;
   localparam int STACK_DEPTH_DEFAULT = 64;

   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [LINE_W-1:0]   line_type;
   typedef logic [DEPTH_W-1:0]  depth_type;
   typedef logic [1:0]          cell_mode_type;

   localparam op_type OP_PUSH  = 3'd0;
   localparam op_type OP_ADD   = 3'd1;
   localparam op_type OP_SUB   = 3'd2;
   localparam op_type OP_MUL   = 3'd3;
   localparam op_type OP_DIV   = 3'd4;
   localparam op_type OP_EQUAL = 3'd5;
   localparam op_type OP_PRINT = 3'd6;
   localparam op_type OP_UNDEF = 3'd7;

   localparam status_type ST_DONE      = 3'd0;
   localparam status_type ST_PRINTED   = 3'd1;
   localparam status_type ST_UNDERFLOW = 3'd2;
   localparam status_type ST_OVERFLOW  = 3'd3;
   localparam status_type ST_DIVZERO   = 3'd4;
   localparam status_type ST_HALT      = 3'd5;
   localparam status_type ST_IGNORED   = 3'd6;

   localparam cell_mode_type MODE_HOLD = 2'd0;
   localparam cell_mode_type MODE_DOWN = 2'd1;
   localparam cell_mode_type MODE_UP   = 2'd2;

   typedef struct packed {
      logic     valid;
      word_type quotient;
   } div_result_type;

endpackage

// ===== rtl/rsc_req_if.sv =====
// Channel that carries tokens into the stack calculator.
interface rsc_req_if;
   logic              valid;
   logic              ready;
   rsc_pkg::op_type   operation;
   rsc_pkg::word_type value;
   rsc_pkg::line_type line;

   modport source (output valid, output operation, output value, output line, input ready);
   modport sink (input valid, input operation, input value, input line, output ready);
endinterface

// ===== rtl/rsc_rsp_if.sv =====
// Channel that carries results out of the stack calculator.
interface rsc_rsp_if;
   logic                valid;
   logic                ready;
   rsc_pkg::status_type status;
   rsc_pkg::word_type   printed_value;
   rsc_pkg::line_type   line_echo;
   rsc_pkg::depth_type  depth;

   modport source (output valid, output status, output printed_value, output line_echo,
                   output depth, input ready);
   modport sink (input valid, input status, input printed_value, input line_echo,
                 input depth, output ready);
endinterface

// ===== rtl/rsc_cell.sv =====
// One stack entry that shifts toward or away from the top with its neighbors.
module rsc_cell (
   input  logic                   clock,
   input  rsc_pkg::cell_mode_type mode,
   input  rsc_pkg::word_type      data_above,
   input  rsc_pkg::word_type      data_below,
   output rsc_pkg::word_type      data_q
);

   rsc_pkg::word_type data_ff;
   rsc_pkg::word_type data_in;

   always_comb begin
      unique case (mode)
         rsc_pkg::MODE_DOWN: data_in = data_above;
         rsc_pkg::MODE_UP:   data_in = data_below;
         default:            data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

// ===== rtl/rsc_divider.sv =====
// Signed divider that truncates toward zero, one quotient bit per cycle.
module rsc_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rsc_pkg::word_type       dividend,
   input  rsc_pkg::word_type       divisor,
   output rsc_pkg::div_result_type result
);

   localparam int W     = rsc_pkg::WORD_W;
   localparam int CNT_W = $clog2(W);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     dsr_ff, dsr_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             valid_ff, valid_in;
   logic [W:0]       trial;

   assign trial = {rem_ff, quo_ff[W-1]} - {1'b0, dsr_ff};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend[W-1] ? (-dividend) : dividend;
         dsr_in   = divisor[W-1] ? (-divisor) : divisor;
         neg_in   = dividend[W-1] ^ divisor[W-1];
         cnt_in   = '0;
         busy_in  = 1'b1;
         valid_in = 1'b0;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[W-2:0], quo_ff[W-1]};
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in  = 1'b0;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign result.valid    = valid_ff;
   assign result.quotient = neg_ff ? (-quo_ff) : quo_ff;

endmodule

// ===== rtl/rpn_stack_calculator.sv =====
// Integer stack calculator that runs one token per accepted word and returns one result word
// for each. The stack is a row of STACK_DEPTH cells with the top in the first cell; a push
// shifts every cell down and a pop or a two-operand operation shifts them up. The block takes
// one token at a time. Push, add, subtract, equal, print, every error and every token after a
// halt finish as they are taken; multiply waits for the register after the multiplier and
// divide for the divider that produces one quotient bit per cycle. A finished result waits
// in the output register, and the next token is taken in the cycle that result leaves.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   rsc_req_if.sink   req_if,
   rsc_rsp_if.source rsp_if
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;

   localparam logic [1:0] ACT_HOLD   = 2'd0;
   localparam logic [1:0] ACT_PUSH   = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_POP    = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   halted_ff, halted_in;
   rsc_pkg::line_type      line_ff, line_in;
   rsc_pkg::word_type      prod_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsc_pkg::status_type    status_ff;
   rsc_pkg::word_type      printed_ff;
   rsc_pkg::line_type      line_echo_ff;

   logic                   out_free;
   logic                   accept;
   logic                   finish;
   rsc_pkg::status_type    fin_status;
   rsc_pkg::word_type      fin_printed;
   rsc_pkg::line_type      fin_line;
   logic [1:0]             action;
   rsc_pkg::word_type      reduce_data;
   rsc_pkg::word_type      alu_result;
   logic                   div_start;
   rsc_pkg::div_result_type div_res;
   rsc_pkg::word_type      top_q;
   rsc_pkg::word_type      next_q;
   rsc_pkg::word_type      cell0_above;
   rsc_pkg::cell_mode_type mode0;
   rsc_pkg::cell_mode_type mode_rest;
   logic                   short_stack;
   logic                   full_stack;
   logic [CNT_W+6:0]       depth_wide;

   rsc_pkg::word_type cell_q [STACK_DEPTH];

   assign top_q       = cell_q[0];
   assign next_q      = cell_q[1];
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE) && out_free;
   assign accept      = req_if.valid && req_if.ready;
   assign short_stack = count_ff < CNT_W'(2);
   assign full_stack  = count_ff == CNT_W'(STACK_DEPTH);

   always_comb begin
      unique case (req_if.operation)
         rsc_pkg::OP_ADD: alu_result = next_q + top_q;
         rsc_pkg::OP_SUB: alu_result = next_q - top_q;
         default:         alu_result = {{(rsc_pkg::WORD_W - 1){1'b0}}, next_q == top_q};
      endcase
   end

   always_comb begin
      finish      = 1'b0;
      fin_status  = rsc_pkg::ST_DONE;
      fin_printed = '0;
      fin_line    = req_if.line;
      action      = ACT_HOLD;
      reduce_data = alu_result;
      count_in    = count_ff;
      halted_in   = halted_ff;
      state_in    = state_ff;
      line_in     = line_ff;
      div_start   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               line_in = req_if.line;
               if (halted_ff) begin
                  finish     = 1'b1;
                  fin_status = rsc_pkg::ST_IGNORED;
               end else begin
                  unique case (req_if.operation)
                     rsc_pkg::OP_PUSH: begin
                        finish = 1'b1;
                        if (full_stack) begin
                           fin_status = rsc_pkg::ST_OVERFLOW;
                        end else begin
                           action   = ACT_PUSH;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                     rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_EQUAL: begin
                        finish = 1'b1;
                        if (short_stack) begin
                           fin_status = rsc_pkg::ST_UNDERFLOW;
                        end else begin
                           action   = ACT_REDUCE;
                           count_in = count_ff - CNT_W'(1);
                        end
                     end
                     rsc_pkg::OP_MUL: begin
                        if (short_stack) begin
                           finish     = 1'b1;
                           fin_status = rsc_pkg::ST_UNDERFLOW;
                        end else begin
                           state_in = S_MUL;
                        end
                     end
                     rsc_pkg::OP_DIV: begin
                        if (short_stack) begin
                           finish     = 1'b1;
                           fin_status = rsc_pkg::ST_UNDERFLOW;
                        end else if (top_q == '0) begin
                           finish     = 1'b1;
                           fin_status = rsc_pkg::ST_DIVZERO;
                        end else begin
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end
                     end
                     rsc_pkg::OP_PRINT: begin
                        finish = 1'b1;
                        if (count_ff == '0) begin
                           fin_status = rsc_pkg::ST_UNDERFLOW;
                        end else begin
                           fin_status  = rsc_pkg::ST_PRINTED;
                           fin_printed = top_q;
                           action      = ACT_POP;
                           count_in    = count_ff - CNT_W'(1);
                        end
                     end
                     default: begin
                        finish     = 1'b1;
                        fin_status = rsc_pkg::ST_HALT;
                        halted_in  = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_MUL: begin
            reduce_data = prod_ff;
            fin_line    = line_ff;
            if (out_free) begin
               finish   = 1'b1;
               action   = ACT_REDUCE;
               count_in = count_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            reduce_data = div_res.quotient;
            fin_line    = line_ff;
            if (out_free && div_res.valid) begin
               finish   = 1'b1;
               action   = ACT_REDUCE;
               count_in = count_ff - CNT_W'(1);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      unique case (action)
         ACT_PUSH: begin
            mode0       = rsc_pkg::MODE_DOWN;
            mode_rest   = rsc_pkg::MODE_DOWN;
            cell0_above = req_if.value;
         end
         ACT_REDUCE: begin
            mode0       = rsc_pkg::MODE_DOWN;
            mode_rest   = rsc_pkg::MODE_UP;
            cell0_above = reduce_data;
         end
         ACT_POP: begin
            mode0       = rsc_pkg::MODE_UP;
            mode_rest   = rsc_pkg::MODE_UP;
            cell0_above = req_if.value;
         end
         default: begin
            mode0       = rsc_pkg::MODE_HOLD;
            mode_rest   = rsc_pkg::MODE_HOLD;
            cell0_above = req_if.value;
         end
      endcase
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      rsc_pkg::word_type above_d;
      rsc_pkg::word_type below_d;
      rsc_pkg::cell_mode_type mode_d;
      if (i == 0) begin : g_top
         assign above_d = cell0_above;
         assign mode_d  = mode0;
      end else begin : g_inner
         assign above_d = cell_q[i-1];
         assign mode_d  = mode_rest;
      end
      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_d = '0;
      end else begin : g_link
         assign below_d = cell_q[i+1];
      end
      rsc_cell u_cell (
         .clock      (clock),
         .mode       (mode_d),
         .data_above (above_d),
         .data_below (below_d),
         .data_q     (cell_q[i])
      );
   end

   rsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (next_q),
      .divisor  (top_q),
      .result   (div_res)
   );

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      prod_ff <= next_q * top_q;
      line_ff <= line_in;
      if (finish) begin
         status_ff    <= fin_status;
         printed_ff   <= fin_printed;
         line_echo_ff <= fin_line;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign depth_wide           = {7'b0, count_ff};
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.printed_value = printed_ff;
   assign rsp_if.line_echo     = line_echo_ff;
   assign rsp_if.depth         = depth_wide[6:0];

endmodule

// ===== rtl/rsc_checker.sv =====
// Port checks of the stack calculator and the bind that attaches them.
`include "rpn_stack_calculator_defines.svh"

module rsc_checker #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input rsc_pkg::status_type rsp_status,
   input rsc_pkg::word_type   rsp_printed_value,
   input rsc_pkg::depth_type  rsp_depth
);

   localparam rsc_pkg::depth_type FULL_DEPTH = 7'(STACK_DEPTH);

   logic halt_taken;
   logic not_printed;
   logic is_overflow;
   logic value_zero;
   logic after_halt_ok;
   logic depth_full;
   logic rsp_stalled;

   assign halt_taken    = rsp_valid && rsp_ready && (rsp_status == rsc_pkg::ST_HALT);
   assign not_printed   = rsp_valid && (rsp_status != rsc_pkg::ST_PRINTED);
   assign is_overflow   = rsp_valid && (rsp_status == rsc_pkg::ST_OVERFLOW);
   assign value_zero    = rsp_printed_value == '0;
   assign after_halt_ok = !rsp_valid || (rsp_status == rsc_pkg::ST_IGNORED);
   assign depth_full    = rsp_depth == FULL_DEPTH;
   assign rsp_stalled   = rsp_valid && !rsp_ready;

   `RSC_ASSERT_NOW(a_value_zero, clock, reset, not_printed, value_zero, "value without print")
   `RSC_ASSERT_NEXT(a_halt_sticks, clock, reset, halt_taken, after_halt_ok, "halt not sticky")
   `RSC_ASSERT_NOW(a_overflow_full, clock, reset, is_overflow, depth_full, "overflow not at full")
   `RSC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stalled, rsp_valid, "result dropped")

endmodule

bind rpn_stack_calculator rsc_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rsc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_status        (rsp_if.status),
   .rsp_printed_value (rsp_if.printed_value),
   .rsp_depth         (rsp_if.depth)
);
